// ===== hdl/kvt_pkg.sv =====
// Package for the key/value table: sizes, opcodes, index and data types,
// and the memory access bundle. Depends on nothing.
package kvt_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 2;

    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic signed [DATA_W-1:0]   t_data;
    typedef logic [OPCODE_W-1:0]        t_opcode;

    localparam t_idx    LAST_IDX    = t_idx'(ENTRIES - 1);

    localparam t_opcode OP_UPDATE   = 2'd0;
    localparam t_opcode OP_REMOVE   = 2'd1;
    localparam t_opcode OP_RETRIEVE = 2'd2;
    localparam t_opcode OP_STOP     = 2'd3;

    // One cycle's access to the key and value memories.
    typedef struct packed {
        logic  we;
        t_idx  wr_addr;
        t_data wr_key;
        t_data wr_value;
        t_idx  rd_addr;
    } t_mem_req;

endpackage

// ===== hdl/kvt_if.sv =====
// Valid/ready channel interfaces for requests and responses of the key/value table.
// Depends on kvt_pkg.
interface kvt_req_if import kvt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_data   key;
    t_data   write_value;

    modport source (output valid, output opcode, output key, output write_value, input ready);
    modport sink   (input valid, input opcode, input key, input write_value, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  hit_flag;
    t_data read_value;
    logic  no_room;

    modport source (output valid, output hit_flag, output read_value, output no_room,
                    input ready);
    modport sink   (input valid, input hit_flag, input read_value, input no_room,
                    output ready);
endinterface

// ===== hdl/kvt_store.sv =====
// Key and value memories of the table: one write port, one read port, registered read.
// Depends on kvt_pkg.
module kvt_store import kvt_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_mem,
    output t_data    o_rd_key,
    output t_data    o_rd_value
);

    t_data r_key_mem   [ENTRIES];
    t_data r_value_mem [ENTRIES];
    t_data r_rd_key;
    t_data r_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_key_mem[i_mem.wr_addr]   <= i_mem.wr_key;
            r_value_mem[i_mem.wr_addr] <= i_mem.wr_value;
        end
        r_rd_key   <= r_key_mem[i_mem.rd_addr];
        r_rd_value <= r_value_mem[i_mem.rd_addr];
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_value = r_rd_value;

endmodule

// ===== hdl/kvt_ctrl.sv =====
// Request sequencer: scans the memories for the key and a free entry, keeps the
// entry valid bits, writes back and holds the response register. Depends on kvt_pkg, kvt_if.
module kvt_ctrl import kvt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kvt_req_if.sink         i_req,
    kvt_rsp_if.source       o_rsp,
    output t_mem_req        o_mem,
    input  t_data           i_rd_key,
    input  t_data           i_rd_value
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    t_opcode            r_op, n_op;
    t_data              r_key, n_key;
    t_data              r_wval, n_wval;
    t_idx               r_idx, n_idx;
    logic               r_hit, n_hit;
    t_idx               r_hit_idx, n_hit_idx;
    t_data              r_old, n_old;
    logic               r_free_ok, n_free_ok;
    t_idx               r_free_idx, n_free_idx;

    logic               r_out_vld, n_out_vld;
    logic               r_out_hit, n_out_hit;
    t_data              r_out_value, n_out_value;
    logic               r_out_no_room, n_out_no_room;

    logic               accept;
    logic               can_load;
    logic               load;
    logic               entry_hit;

    assign accept    = i_req.valid && i_req.ready;
    assign can_load  = !r_out_vld || o_rsp.ready;
    assign load      = (r_state == ST_FINISH) && can_load;
    assign entry_hit = r_valid[r_idx] && (i_rd_key == r_key);

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_op          = r_op;
        n_key         = r_key;
        n_wval        = r_wval;
        n_idx         = r_idx;
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_old         = r_old;
        n_free_ok     = r_free_ok;
        n_free_idx    = r_free_idx;
        n_out_vld     = r_out_vld && !o_rsp.ready;
        n_out_hit     = r_out_hit;
        n_out_value   = r_out_value;
        n_out_no_room = r_out_no_room;
        o_mem.we       = 1'b0;
        o_mem.wr_addr  = r_hit ? r_hit_idx : r_free_idx;
        o_mem.wr_key   = r_key;
        o_mem.wr_value = r_wval;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op      = i_req.opcode;
                    n_key     = i_req.key;
                    n_wval    = i_req.write_value;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = (i_req.opcode == OP_STOP) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Data on the read port belongs to entry r_idx.
                if (!r_valid[r_idx] && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_idx;
                end
                if (entry_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                    n_old     = i_rd_value;
                    n_state   = ST_FINISH;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx = r_idx + t_idx'(1);
                end
            end
            ST_FINISH: begin
                if (can_load) begin
                    n_state       = ST_IDLE;
                    n_out_vld     = 1'b1;
                    n_out_hit     = 1'b0;
                    n_out_value   = '0;
                    n_out_no_room = 1'b0;
                    unique case (r_op)
                        OP_UPDATE: begin
                            if (r_hit) begin
                                o_mem.we    = 1'b1;
                                n_out_hit   = 1'b1;
                                n_out_value = r_old;
                            end else if (r_free_ok) begin
                                o_mem.we            = 1'b1;
                                n_valid[r_free_idx] = 1'b1;
                                n_out_hit           = 1'b1;
                                n_out_value         = r_wval;
                            end else begin
                                n_out_no_room = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_out_hit          = 1'b1;
                                n_out_value        = r_old;
                            end
                        end
                        OP_RETRIEVE: begin
                            if (r_hit) begin
                                n_out_hit   = 1'b1;
                                n_out_value = r_old;
                            end
                        end
                        OP_STOP: begin
                            n_out_hit = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_mem.rd_addr = n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_key         <= n_key;
        r_wval        <= n_wval;
        r_idx         <= n_idx;
        r_hit         <= n_hit;
        r_hit_idx     <= n_hit_idx;
        r_old         <= n_old;
        r_free_ok     <= n_free_ok;
        r_free_idx    <= n_free_idx;
        r_out_hit     <= n_out_hit;
        r_out_value   <= n_out_value;
        r_out_no_room <= n_out_no_room;
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.hit_flag    = r_out_hit;
    assign o_rsp.read_value  = r_out_value;
    assign o_rsp.no_room     = r_out_no_room;

    // A full-table refusal is only given when every entry is in use.
    a_no_room_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_out_no_room) |-> (&r_valid))
        else $error("no_room reported with a free entry");

    // A new key is only ever written into an entry that was free.
    a_new_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && !r_hit) |-> !r_valid[r_free_idx])
        else $error("new key written over a live entry");

    // At most one entry comes into use per request.
    a_one_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_valid) <= $countones($past(r_valid)) + 1))
        else $error("more than one entry became valid");

    // The memories are only written in the write-back cycle.
    a_write_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (r_state == ST_FINISH))
        else $error("memory write outside write-back");

endmodule

// ===== hdl/key_value_table_top.sv =====
// Top level of the key/value table: joins the request sequencer and the memories.
// Depends on kvt_pkg, kvt_if, kvt_store, kvt_ctrl.
//
//   Channel   Direction  Payload                                Accepted when
//   i_req     in         opcode[1:0], key[31:0], write_value    valid && ready
//   o_rsp     out        hit_flag, read_value[31:0], no_room    valid && ready
//
// A request is taken in idle; the scan then examines one entry per cycle (up to
// ENTRIES, fewer when the key is found early, none for stop), and write-back then
// updates the table and loads the response; only then is the next request taken.
// The scan is bound by the single read port of the key and value memories.
// Synchronous active-low reset empties the table by clearing the valid bits;
// memory contents are not cleared. A response not yet taken holds the block in
// write-back; a new request is taken while an earlier response is still waiting.
module key_value_table_top import kvt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvt_req_if.sink    i_req,
    kvt_rsp_if.source  o_rsp
);

    t_mem_req mem_req;
    t_data    rd_key;
    t_data    rd_value;

    // Sequencer: owns the valid bits, the scan and the response register.
    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_mem      (mem_req),
        .i_rd_key   (rd_key),
        .i_rd_value (rd_value)
    );

    // Key and value memories, read one entry per cycle through a registered read port.
    kvt_store u_store (
        .i_clk      (i_clk),
        .i_mem      (mem_req),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value)
    );

endmodule
